// ===== src/srr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants for the selective repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int unsigned SEQ_W        = 16;
  localparam int unsigned PAYLOAD_W    = 32;
  localparam int unsigned WINDOW_DEF   = 4;
  localparam int unsigned SEQ_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  typedef struct packed {
    logic [SEQ_W-1:0]     seq;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

  typedef struct packed {
    kind_e                kind;
    logic [SEQ_W-1:0]     seq_out;
    logic [PAYLOAD_W-1:0] data_out;
    logic                 duplicate;
    logic                 last;
  } result_t;

endpackage

// ===== src/srr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module srr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/selective_repeat_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receiver_top
// Frame receiver: acknowledges or discards each frame and delivers in-order payloads.
// The acknowledge or discard result is computed in ST_CLASS from the captured
// frame and registered to res_o; then D deliveries follow, D = 0..WINDOW,
// one result per cycle, set by the single read port of the slot RAM.
// Reset clears the window base, the ring head and the slot valid bits.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_top #(
  parameter int unsigned WINDOW   = srr_pkg::WINDOW_DEF,
  parameter int unsigned SEQ_BITS = srr_pkg::SEQ_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  srr_pkg::frame_t  frame_i,
  output logic             res_valid_o,
  output srr_pkg::result_t res_o
);

  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned XW = SEQ_BITS + 8;
  localparam logic [XW-1:0]  MOD_X = XW'(1) << SEQ_BITS;
  localparam logic [XW-1:0]  WIN_X = XW'(WINDOW);
  localparam logic [IW:0]    WIN_P = (IW + 1)'(WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_CLASS   = 3'b010,
    ST_DELIVER = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [SEQ_BITS-1:0]           seq_q;
  logic [srr_pkg::PAYLOAD_W-1:0] payload_q;
  logic [SEQ_BITS-1:0]           base_q, base_d;
  logic [IW-1:0]                 head_q, head_d;
  logic [WINDOW-1:0]             filled_q, filled_d;
  logic                          fwd_q, fwd_d;
  logic                          res_valid_q, res_valid_d;
  srr_pkg::result_t              res_q, res_d;

  logic [SEQ_BITS-1:0]           seq_dist;
  logic [XW-1:0]                 dist_x;
  logic                          in_win, behind;
  logic [IW:0]                   psum;
  logic [IW-1:0]                 phys;
  logic [IW:0]                   hsum;
  logic [IW-1:0]                 head_nxt;
  logic [WINDOW-1:0]             filled_clr;
  logic                          we;
  logic [IW-1:0]                 raddr;
  logic [srr_pkg::PAYLOAD_W-1:0] rdata;
  logic [31:0]                   seq_wide, base_wide;

  assign seq_dist = seq_q - base_q;
  assign dist_x   = XW'(seq_dist);
  assign in_win   = dist_x < WIN_X;
  assign behind   = (dist_x + WIN_X) >= MOD_X;
  assign psum     = (IW + 1)'(head_q) + (IW + 1)'(seq_dist);
  assign phys     = (psum >= WIN_P) ? IW'(psum - WIN_P) : IW'(psum);
  assign hsum     = (IW + 1)'(head_q) + (IW + 1)'(1);
  assign head_nxt = (hsum >= WIN_P) ? IW'(hsum - WIN_P) : IW'(hsum);
  assign seq_wide  = 32'(seq_q);
  assign base_wide = 32'(base_q);

  always_comb begin
    filled_clr         = filled_q;
    filled_clr[head_q] = 1'b0;
  end

  srr_ram #(
    .WIDTH (srr_pkg::PAYLOAD_W),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (phys),
    .wdata_i (payload_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    head_d      = head_q;
    filled_d    = filled_q;
    fwd_d       = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    raddr       = head_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: begin
        res_valid_d       = 1'b1;
        res_d.seq_out     = seq_wide[15:0];
        res_d.data_out    = '0;
        res_d.duplicate   = 1'b0;
        res_d.last        = 1'b1;
        state_d           = ST_IDLE;
        if (in_win) begin
          res_d.kind      = srr_pkg::KIND_ACK;
          res_d.duplicate = filled_q[phys];
          we              = !filled_q[phys];
          if (we) begin
            filled_d[phys] = 1'b1;
          end
          fwd_d = we && (phys == head_q);
          if (filled_q[head_q] || (we && (phys == head_q))) begin
            res_d.last = 1'b0;
            state_d    = ST_DELIVER;
          end
        end else if (behind) begin
          res_d.kind = srr_pkg::KIND_ACK;
        end else begin
          res_d.kind = srr_pkg::KIND_DISCARD;
        end
      end
      ST_DELIVER: begin
        res_valid_d     = 1'b1;
        res_d.kind      = srr_pkg::KIND_DELIVER;
        res_d.seq_out   = base_wide[15:0];
        res_d.data_out  = fwd_q ? payload_q : rdata;
        res_d.duplicate = 1'b0;
        filled_d        = filled_clr;
        head_d          = head_nxt;
        base_d          = base_q + SEQ_BITS'(1);
        raddr           = head_nxt;
        if (filled_clr[head_nxt]) begin
          res_d.last = 1'b0;
        end else begin
          res_d.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      head_q      <= '0;
      filled_q    <= '0;
      fwd_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      head_q      <= head_d;
      filled_q    <= filled_d;
      fwd_q       <= fwd_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) begin
      seq_q     <= SEQ_BITS'(32'(frame_i.seq));
      payload_q <= frame_i.payload;
    end
    res_q <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/srr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_checker
// Port-level checks on the receiver's command and result beats.
// ----------------------------------------------------------------------------
module srr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             res_valid_o,
  input srr_pkg::result_t res_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !res_valid_o)
    else $error("accepted beat did not raise busy");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("busy held after final result");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final result while idle");

  a_discard_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == srr_pkg::KIND_DISCARD) |->
      res_o.last && !res_o.duplicate && (res_o.data_out == '0))
    else $error("malformed discard result");

  a_deliver_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == srr_pkg::KIND_DELIVER) |->
      $past(res_valid_o) && !$past(res_o.last))
    else $error("delivery without preceding result");

endmodule

bind selective_repeat_receiver_top srr_checker u_srr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
